// File: rtl/chaikin_subdivision_pass_defines.svh
// ----------------------------------------------------------------------------
// Chaikin subdivision pass: assertion macros
// Shared concurrent-check shorthands, reset-gated on rst_n.
// ----------------------------------------------------------------------------
`ifndef CHAIKIN_SUBDIVISION_PASS_DEFINES_SVH
`define CHAIKIN_SUBDIVISION_PASS_DEFINES_SVH

// same-cycle implication
`define CHK_IMPLY(name, clk, rst_n, cond, conseq, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(name, clk, rst_n, cond, conseq, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// File: rtl/chaikin_pkg.sv
// ----------------------------------------------------------------------------
// chaikin_pkg
// Word, job and status types shared by the Chaikin subdivision pass.
// ----------------------------------------------------------------------------
package chaikin_pkg;

    // coordinate width, signed Q2.14
    localparam int COORD_W = 16;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x_in;
        coord_t y_in;
        coord_t z_in;
        logic   last_point;
    } point_word_t;

    typedef struct packed {
        coord_t x_out;
        coord_t y_out;
        coord_t z_out;
        logic   end_of_run;
        logic   end_of_curve;
    } refined_word_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec3_t;

    // what the back end has to emit for one pair (or lone point)
    typedef enum logic [2:0] {
        JOB_LONE,
        JOB_FIRST,
        JOB_FIRST_LAST,
        JOB_INNER,
        JOB_LAST
    } job_kind_t;

    typedef struct packed {
        job_kind_t kind;
        vec3_t     p;
        vec3_t     q;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic have_first;
        logic past_first;
    } front_stat_t;

endpackage

// File: rtl/chaikin_front.sv
// ----------------------------------------------------------------------------
// chaikin_front
// Accepts points, tracks polyline position, pushes one job per pair or lone point.
// ----------------------------------------------------------------------------
module chaikin_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      point_valid,
    output logic                      point_stall,
    input  chaikin_pkg::point_word_t  point_word,
    input  chaikin_pkg::q_stat_t      q_stat,
    output chaikin_pkg::q_push_t      q_push,
    output chaikin_pkg::front_stat_t  stat
);

    logic                have_first_reg, have_first_next;
    logic                past_first_reg, past_first_next;
    chaikin_pkg::vec3_t  prev_reg;
    chaikin_pkg::vec3_t  cur;
    logic                accept;

    assign point_stall = q_stat.full;
    assign accept      = point_valid && !q_stat.full;

    assign cur.x = point_word.x_in;
    assign cur.y = point_word.y_in;
    assign cur.z = point_word.z_in;

    always_comb
    begin
        q_push.job.p    = prev_reg;
        q_push.job.q    = cur;
        q_push.valid    = accept && (have_first_reg || point_word.last_point);
        if (!have_first_reg)
        begin
            q_push.job.kind = chaikin_pkg::JOB_LONE;
        end
        else if (!past_first_reg)
        begin
            q_push.job.kind = point_word.last_point ? chaikin_pkg::JOB_FIRST_LAST
                                                    : chaikin_pkg::JOB_FIRST;
        end
        else
        begin
            q_push.job.kind = point_word.last_point ? chaikin_pkg::JOB_LAST
                                                    : chaikin_pkg::JOB_INNER;
        end
    end

    // a last point always closes the polyline
    assign have_first_next = !point_word.last_point;
    assign past_first_next = have_first_reg && !point_word.last_point;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first_reg <= 1'b0;
            past_first_reg <= 1'b0;
        end
        else if (accept)
        begin
            have_first_reg <= have_first_next;
            past_first_reg <= past_first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_reg <= cur;
        end
    end

    assign stat.have_first = have_first_reg;
    assign stat.past_first = past_first_reg;

endmodule

// File: rtl/chaikin_queue.sv
// ----------------------------------------------------------------------------
// chaikin_queue
// Small job FIFO between front and back; head is shown combinationally.
// ----------------------------------------------------------------------------
module chaikin_queue
#(
    parameter int DEPTH = 4     // 2 or more
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  chaikin_pkg::q_push_t  q_push,
    input  logic                  pop,
    output chaikin_pkg::job_t     head,
    output chaikin_pkg::q_stat_t  stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    chaikin_pkg::job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (q_push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !q_push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.valid)
        begin
            mem[wr_ptr_reg] <= q_push.job;
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// File: rtl/chaikin_back.sv
// ----------------------------------------------------------------------------
// chaikin_back
// Steps through each job's refined points, one per cycle while the output
// is not stalled, into an output register.
// ----------------------------------------------------------------------------
module chaikin_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  chaikin_pkg::job_t           head,
    input  chaikin_pkg::q_stat_t        q_stat,
    output logic                        pop,
    output logic                        refined_valid,
    input  logic                        refined_stall,
    output chaikin_pkg::refined_word_t  refined_word
);

    localparam int W = chaikin_pkg::COORD_W;

    // floor((a+b)/2)
    function automatic chaikin_pkg::coord_t blend_mid(chaikin_pkg::coord_t a,
                                                      chaikin_pkg::coord_t b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        return s[W:1];
    endfunction

    // floor((3a+b)/4)
    function automatic chaikin_pkg::coord_t blend_near(chaikin_pkg::coord_t a,
                                                       chaikin_pkg::coord_t b);
        logic signed [W+1:0] ae;
        logic signed [W+1:0] s;
        ae = {{2{a[W-1]}}, a};
        s  = {ae[W:0], 1'b0} + ae + {{2{b[W-1]}}, b};
        return s[W+1:2];
    endfunction

    function automatic chaikin_pkg::vec3_t vmid(chaikin_pkg::vec3_t a,
                                                chaikin_pkg::vec3_t b);
        chaikin_pkg::vec3_t r;
        r.x = blend_mid(a.x, b.x);
        r.y = blend_mid(a.y, b.y);
        r.z = blend_mid(a.z, b.z);
        return r;
    endfunction

    function automatic chaikin_pkg::vec3_t vnear(chaikin_pkg::vec3_t a,
                                                 chaikin_pkg::vec3_t b);
        chaikin_pkg::vec3_t r;
        r.x = blend_near(a.x, b.x);
        r.y = blend_near(a.y, b.y);
        r.z = blend_near(a.z, b.z);
        return r;
    endfunction

    logic                        work_valid_reg;
    chaikin_pkg::job_t           work_reg;
    logic [1:0]                  step_reg;
    logic                        out_valid_reg;
    chaikin_pkg::refined_word_t  out_reg;

    logic [1:0]                  last_step;
    logic                        out_load;
    logic                        work_done;
    chaikin_pkg::vec3_t          pt;
    chaikin_pkg::vec3_t          pt_mid;
    chaikin_pkg::vec3_t          pt_near_p;
    chaikin_pkg::vec3_t          pt_near_q;
    logic                        eor;
    logic                        eoc;

    assign pt_mid    = vmid(work_reg.p, work_reg.q);
    assign pt_near_p = vnear(work_reg.p, work_reg.q);
    assign pt_near_q = vnear(work_reg.q, work_reg.p);

    always_comb
    begin
        pt        = work_reg.q;
        eor       = 1'b0;
        eoc       = 1'b0;
        last_step = 2'd1;
        unique case (work_reg.kind)
            chaikin_pkg::JOB_LONE:
            begin
                last_step = 2'd0;
                eor       = 1'b1;
                eoc       = 1'b1;
            end
            chaikin_pkg::JOB_FIRST:
            begin
                pt  = (step_reg == 2'd0) ? work_reg.p : pt_mid;
                eor = (step_reg == 2'd1);
            end
            chaikin_pkg::JOB_FIRST_LAST:
            begin
                last_step = 2'd3;
                unique case (step_reg)
                    2'd0:    pt = work_reg.p;
                    2'd1:    pt = pt_mid;
                    2'd2:    pt = pt_mid;
                    default:
                    begin
                        pt  = work_reg.q;
                        eor = 1'b1;
                        eoc = 1'b1;
                    end
                endcase
            end
            chaikin_pkg::JOB_INNER:
            begin
                pt  = (step_reg == 2'd0) ? pt_near_p : pt_near_q;
                eor = (step_reg == 2'd1);
            end
            chaikin_pkg::JOB_LAST:
            begin
                pt  = (step_reg == 2'd0) ? pt_mid : work_reg.q;
                eor = (step_reg == 2'd1);
                eoc = (step_reg == 2'd1);
            end
            default:
            begin
                last_step = 2'd0;
            end
        endcase
    end

    assign out_load  = work_valid_reg && (!out_valid_reg || !refined_stall);
    assign work_done = out_load && (step_reg == last_step);
    assign pop       = !q_stat.empty && (!work_valid_reg || work_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                work_valid_reg <= 1'b1;
                step_reg       <= '0;
            end
            else if (work_done)
            begin
                work_valid_reg <= 1'b0;
            end
            else if (out_load)
            begin
                step_reg <= step_reg + 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!refined_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg <= head;
        end
        if (out_load)
        begin
            out_reg.x_out        <= pt.x;
            out_reg.y_out        <= pt.y;
            out_reg.z_out        <= pt.z;
            out_reg.end_of_run   <= eor;
            out_reg.end_of_curve <= eoc;
        end
    end

    assign refined_valid = out_valid_reg;
    assign refined_word  = out_reg;

endmodule

// File: rtl/chaikin_subdivision_pass.sv
// ----------------------------------------------------------------------------
// chaikin_subdivision_pass
// One pass of Chaikin corner cutting with fixed end masks over a stream
// of 3-D signed Q2.14 points.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake                    word
//  -------   ---   --------------------------   ---------------------------
//  point     in    point_valid / point_stall    point_word   (x,y,z,last)
//  refined   out   refined_valid / refined_stall refined_word (x,y,z,eor,eoc)
//
//  Each point yields 0 to 4 refined words; the back end emits one word per
//  cycle while refined_stall is low, so an interior point yields 2 words.
//  On its way out, a point's first refined word passes the queue, the work
//  register and the output register, in that order.
//  Reset clears queue, polyline position and valid flags; no clearing pass.
//  point_stall rises only when the job queue is full; refined_stall holds
//  the output register while the queue absorbs points until it is full.
//
// Front end: tracks prev point and whether the current pair is the first,
// and turns each pair into a job (first, first+last, interior, last, lone).
// A first point that is not also last only updates state.
// Queue: QUEUE_DEPTH jobs, decouples point intake from result output.
// Back end: steps through a job's results with a 2-bit counter, blending
// with shift-adds (floor division), into the output register. The next job
// is loaded in the same cycle as the previous job's final word, so words
// flow back to back across jobs.
// ----------------------------------------------------------------------------
`include "chaikin_subdivision_pass_defines.svh"

module chaikin_subdivision_pass
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        point_valid,
    output logic                        point_stall,
    input  chaikin_pkg::point_word_t    point_word,
    output logic                        refined_valid,
    input  logic                        refined_stall,
    output chaikin_pkg::refined_word_t  refined_word
);

    chaikin_pkg::q_push_t      q_push;
    chaikin_pkg::q_stat_t      q_stat;
    chaikin_pkg::job_t         q_head;
    chaikin_pkg::front_stat_t  f_stat;
    logic                      q_pop;

    chaikin_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point_word  (point_word),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .stat        (f_stat)
    );

    chaikin_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (q_pop),
        .head   (q_head),
        .stat   (q_stat)
    );

    chaikin_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .q_stat        (q_stat),
        .pop           (q_pop),
        .refined_valid (refined_valid),
        .refined_stall (refined_stall),
        .refined_word  (refined_word)
    );

    // queue must never overflow or underflow
    `CHK_IMPLY(a_no_push_full, clk, rst_n, q_push.valid, !q_stat.full, "push into full queue")
    `CHK_IMPLY(a_no_pop_empty, clk, rst_n, q_pop, !q_stat.empty, "pop from empty queue")

    // a last point closes the polyline
    `CHK_NEXT(a_last_closes, clk, rst_n,
              point_valid && !point_stall && point_word.last_point,
              !f_stat.have_first, "polyline not closed after last point")

    // end of curve is always the end of its point's run
    `CHK_IMPLY(a_eoc_eor, clk, rst_n, refined_valid && refined_word.end_of_curve,
               refined_word.end_of_run, "end_of_curve without end_of_run")

endmodule
